>>> rtl/core/tlrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrt_pkg - shared types and constants of the two-lane race timer
// Phase codes, state and result records, and port widths.
// ----------------------------------------------------------------------------
package tlrt_pkg;

  localparam int TIME_W      = 32;
  localparam int HOLD_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  localparam logic              DUAL_MODE_RST  = 1'b1;
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = HOLD_W'(2000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WAIT   = 2'd1,
    PH_RUN    = 2'd2,
    PH_RESULT = 2'd3
  } phase_t;

  typedef struct packed {
    logic press_one;
    logic press_two;
    logic release_one;
    logic release_two;
    logic select_press;
  } tlrt_event_t;

  typedef struct packed {
    phase_t             phase;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  first_lane_time;
    logic [TIME_W-1:0]  second_lane_time;
    logic               first_lane_valid;
    logic               second_lane_valid;
    logic               hold_active;
    logic [HOLD_W-1:0]  hold_count;
  } tlrt_state_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] running_time;
    logic [TIME_W-1:0] lane_one_time;
    logic [TIME_W-1:0] lane_two_time;
    logic              lane_one_done;
    logic              lane_two_done;
    logic              leave_mode;
    logic              reset_done;
  } tlrt_result_t;

endpackage

>>> rtl/core/two_lane_race_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_lane_race_timer - two-lane buzzer race timer
// Takes one request per millisecond tick with its button events and returns
// one result per tick: phase, running time and the captured lane times.
// ----------------------------------------------------------------------------
// Result: an accepted request's result is in the output register on the next cycle.
// Throughput: one request per cycle unless the output stalls; the tick update is
//   one pass of increment and compare logic between the state and output registers.
// Reset: rst clears the phase to idle, all times, flags and the hold, empties
//   the output register and loads dual_mode = 1 and hold_ticks = 2000.
module two_lane_race_timer import tlrt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // request stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [0] press_one, [1] press_two, [2] release_one, [3] release_two,
  // [4] select_press, [7:5] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [1:0] phase, [33:2] running_time, [65:34] lane_one_time,
  // [97:66] lane_two_time, [98] lane_one_done, [99] lane_two_done,
  // [100] leave_mode, [101] reset_done, [103:102] zero
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // Configuration registers, written only while no request is in flight; user's duty, not enforced.
  logic              dual_mode;
  logic [HOLD_W-1:0] hold_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      dual_mode  <= DUAL_MODE_RST;
      hold_ticks <= HOLD_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_DUAL_MODE:  dual_mode  <= cfg_wdata[0];
        REG_HOLD_TICKS: hold_ticks <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the tick's button events.
  tlrt_event_t ev;
  assign ev.press_one    = s_tdata[0];
  assign ev.press_two    = s_tdata[1];
  assign ev.release_one  = s_tdata[2];
  assign ev.release_two  = s_tdata[3];
  assign ev.select_press = s_tdata[4];

  tlrt_state_t  st;
  tlrt_state_t  st_next;
  tlrt_result_t res_next;
  tlrt_result_t res;

  tlrt_step u_step (
    .cur        (st),
    .ev         (ev),
    .dual_mode  (dual_mode),
    .hold_ticks (hold_ticks),
    .nxt        (st_next),
    .res        (res_next)
  );

  // Take a new request whenever the output register is empty or drains this
  // cycle, so a result leaving the register costs no bubble.
  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Advance the timer state on each accepted tick; hold it otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase             <= PH_IDLE;
      st.elapsed           <= '0;
      st.first_lane_time   <= '0;
      st.second_lane_time  <= '0;
      st.first_lane_valid  <= 1'b0;
      st.second_lane_valid <= 1'b0;
      st.hold_active       <= 1'b0;
      st.hold_count        <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Output register: valid flag is control, the record is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_tdata = {2'b00, res.reset_done, res.leave_mode,
                    res.lane_two_done, res.lane_one_done,
                    res.lane_two_time, res.lane_one_time,
                    res.running_time, res.phase};

  // A finished hold or a select exit always lands in idle.
  a_exit_to_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.reset_done || res.leave_mode) |-> res.phase == PH_IDLE)
    else $error("reset_done or leave_mode shown outside idle");

  // While waiting, the clock has not started yet.
  a_wait_zero: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_WAIT |-> st.elapsed == '0)
    else $error("elapsed nonzero while waiting");

  // A run with both lanes captured must already have stopped.
  a_run_not_done: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_RUN |-> !(st.first_lane_valid && st.second_lane_valid))
    else $error("still running with both lanes captured");

  // An accepted tick always produces a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted tick left no result");

endmodule

>>> rtl/core/tlrt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrt_step - one-tick update of the race timer
// Next state and result record for one tick of button events.
// ----------------------------------------------------------------------------
module tlrt_step import tlrt_pkg::*; (
  input  tlrt_state_t       cur,
  input  tlrt_event_t       ev,
  input  logic              dual_mode,
  input  logic [HOLD_W-1:0] hold_ticks,
  output tlrt_state_t       nxt,
  output tlrt_result_t      res
);

  logic [TIME_W-1:0] elapsed_inc;
  logic [HOLD_W-1:0] hold_inc;
  logic              any_press;
  logic              leave;
  logic              hold_done;

  assign elapsed_inc = (cur.elapsed == TIME_MAX) ? cur.elapsed : cur.elapsed + 1'b1;
  assign hold_inc    = (cur.hold_count == HOLD_MAX) ? cur.hold_count : cur.hold_count + 1'b1;
  assign any_press   = ev.press_one | ev.press_two;

  always_comb begin
    nxt       = cur;
    leave     = 1'b0;
    hold_done = 1'b0;
    unique case (cur.phase)
      PH_IDLE: begin
        nxt.elapsed           = '0;
        nxt.first_lane_time   = '0;
        nxt.second_lane_time  = '0;
        nxt.first_lane_valid  = 1'b0;
        nxt.second_lane_valid = 1'b0;
        nxt.phase             = PH_WAIT;
      end
      PH_WAIT: begin
        // select wins over the buzzers
        if (ev.select_press) begin
          leave     = 1'b1;
          nxt.phase = PH_IDLE;
        end else if (any_press) begin
          nxt.phase = PH_RUN;
        end
      end
      PH_RUN: begin
        nxt.elapsed = elapsed_inc;
        if (!dual_mode) begin
          if (any_press) begin
            nxt.first_lane_time  = elapsed_inc;
            nxt.first_lane_valid = 1'b1;
            nxt.phase            = PH_RESULT;
          end
        end else begin
          if (!cur.first_lane_valid && ev.press_one) begin
            nxt.first_lane_time  = elapsed_inc;
            nxt.first_lane_valid = 1'b1;
          end
          if (!cur.second_lane_valid && ev.press_two) begin
            nxt.second_lane_time  = elapsed_inc;
            nxt.second_lane_valid = 1'b1;
          end
          if (nxt.first_lane_valid && nxt.second_lane_valid) begin
            nxt.phase = PH_RESULT;
          end
        end
      end
      PH_RESULT: begin
        if (!cur.hold_active) begin
          if (any_press) begin
            nxt.hold_active = 1'b1;
            nxt.hold_count  = '0;
          end
        end else begin
          nxt.hold_count = hold_inc;
          if (hold_inc >= hold_ticks) begin
            nxt.hold_active = 1'b0;
            hold_done       = 1'b1;
            nxt.phase       = PH_IDLE;
          end else if (ev.release_one || ev.release_two) begin
            nxt.hold_active = 1'b0;
          end
        end
      end
      default: nxt = cur;
    endcase
  end

  always_comb begin
    res.phase         = nxt.phase;
    res.running_time  = nxt.elapsed;
    res.lane_one_time = nxt.first_lane_valid ? nxt.first_lane_time : '0;
    res.lane_two_time = nxt.second_lane_valid ? nxt.second_lane_time : '0;
    res.lane_one_done = nxt.first_lane_valid;
    res.lane_two_done = nxt.second_lane_valid;
    res.leave_mode    = leave;
    res.reset_done    = hold_done;
  end

endmodule
